/* hw/rtl/ordrob_pkg.sv */
package ordrob_pkg;

    // Slot numbers on the ports and in the count register
    localparam int SLOT_W = 6;
    // Head pointer may step one past the highest slot number
    localparam int HEAD_W = SLOT_W + 1;
    // One presence flag per slot number, indexed directly by slot
    localparam int PRES_N = 1 << SLOT_W;

    localparam int DEPTH_DEF     = 32;
    localparam int WORD_BITS_DEF = 32;

    // First slot of a stream
    localparam logic [HEAD_W-1:0] HEAD_FIRST = HEAD_W'(1);

    // Store access request from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_idx;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_idx;
    } mem_req_t;

    // Result marker from the sequencer
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic              last;
        logic              bad;
    } res_meta_t;

endpackage

/* hw/rtl/ordrob_store.sv */
module ordrob_store
    import ordrob_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                 clk,
    input  mem_req_t             req,
    input  logic [WORD_BITS-1:0] wr_data,
    output logic [WORD_BITS-1:0] rd_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [EXT_W-1:0]     wr_ext;
    logic [EXT_W-1:0]     rd_ext;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;

    // Map slot index onto the memory address width
    assign wr_ext  = EXT_W'(req.wr_idx);
    assign rd_ext  = EXT_W'(req.rd_idx);
    assign wr_addr = wr_ext[IDX_W-1:0];
    assign rd_addr = rd_ext[IDX_W-1:0];

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/ordrob_ctrl.sv */
module ordrob_ctrl
    import ordrob_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SLOT_W-1:0] slot_id,
    input  logic              cfg_valid,
    input  logic [SLOT_W-1:0] cfg_data,
    output logic              cfg_ready,
    output logic              busy,
    output mem_req_t          req,
    output res_meta_t         meta
);

    localparam int CAP_INT = (DEPTH < PRES_N - 1) ? DEPTH : PRES_N - 1;
    localparam logic [SLOT_W-1:0] DEPTH_CAP = SLOT_W'(CAP_INT);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [HEAD_W-1:0]   head_reg, head_next;
    logic [SLOT_W-1:0]   count_reg, count_next;
    logic [PRES_N-1:0]   pres_reg, pres_next;
    logic                res_valid_reg, res_valid_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic                res_last_reg, res_last_next;
    logic                res_bad_reg, res_bad_next;

    logic                accept;
    logic                cfg_wr;
    logic                slot_ok;
    logic [HEAD_W-1:0]   count_ext;
    logic [HEAD_W-1:0]   head_plus;
    logic                cur_ok;
    logic                nxt_ok;
    logic [SLOT_W-1:0]   cfg_clamped;

    assign busy      = (state_reg != ST_IDLE);
    // Count writes only while idle and no insert is offered
    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign accept    = start && !busy;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Slot range check against the active count
    assign slot_ok   = (slot_id != '0) && (slot_id <= count_reg);

    // Head slot and the one after it ready to release
    assign count_ext = HEAD_W'(count_reg);
    assign head_plus = head_reg + HEAD_FIRST;
    assign cur_ok    = (head_reg <= count_ext) && pres_reg[head_reg[SLOT_W-1:0]];
    assign nxt_ok    = (head_plus <= count_ext) && pres_reg[head_plus[SLOT_W-1:0]];

    // Count register clamp to 1..DEPTH
    always_comb
    begin
        cfg_clamped = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_clamped = SLOT_W'(1);
        end
        else if (cfg_data > DEPTH_CAP)
        begin
            cfg_clamped = DEPTH_CAP;
        end
    end

    // Sequencer: count writes; store on insert, then release consecutive present slots; error item on a bad slot
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        pres_next      = pres_reg;
        res_valid_next = 1'b0;
        res_slot_next  = '0;
        res_last_next  = 1'b0;
        res_bad_next   = 1'b0;
        req.wr_en      = 1'b0;
        req.wr_idx     = slot_id - SLOT_W'(1);
        req.rd_en      = 1'b0;
        req.rd_idx     = head_reg[SLOT_W-1:0] - SLOT_W'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr)
                begin
                    count_next = cfg_clamped;
                    pres_next  = '0;
                    head_next  = HEAD_FIRST;
                end
                else if (accept)
                begin
                    if (slot_ok)
                    begin
                        req.wr_en          = 1'b1;
                        pres_next[slot_id] = 1'b1;
                        state_next         = ST_DRAIN;
                    end
                    else
                    begin
                        // one error item, no state change
                        res_valid_next = 1'b1;
                        res_bad_next   = 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (cur_ok)
                begin
                    req.rd_en      = 1'b1;
                    res_valid_next = 1'b1;
                    res_slot_next  = head_reg[SLOT_W-1:0];
                    res_last_next  = !nxt_ok;
                    head_next      = head_plus;
                    if (!nxt_ok)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= HEAD_FIRST;
            count_reg     <= DEPTH_CAP;
            pres_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pres_reg      <= pres_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Result marker fields, aligned with the store read data
    always_ff @(posedge clk)
    begin
        res_slot_reg <= res_slot_next;
        res_last_reg <= res_last_next;
        res_bad_reg  <= res_bad_next;
    end

    assign meta.valid = res_valid_reg;
    assign meta.slot  = res_slot_reg;
    assign meta.last  = res_last_reg;
    assign meta.bad   = res_bad_reg;

endmodule

/* hw/rtl/ordered_stream_reorder_buffer_unit.sv */
// Reorder buffer for a numbered stream of words.
// Input: present slot_id and payload with start high; the item is taken at a
// clock edge where start is high and busy is low. Slots run from 1 to the
// active count; the payload is stored and the slot marked present.
// Output: every consecutive present slot from the head onward is released in
// order, one item per cycle, each on the result ports for a single cycle with
// result_valid high; the last item of a run has last set. An insert that
// releases nothing gives no item. A slot of 0 or above the count gives one
// item with bad_slot set and all other fields zero.
// Timing: after an insert the unit is busy in its drain state for the release
// run, also when nothing is released; each word comes out in the cycle after its
// store read, bounded by the single read port of the store. An error item
// appears in the cycle after the insert and the unit is free again.
// Configuration: cfg_valid/cfg_ready write the slot count (0 reads as 1, values
// above DEPTH as DEPTH); the write clears all presence and sets the head to 1.
// cfg_ready is low while busy and while start is high.
// Reset: count min(DEPTH, 63), head 1, no slot present. The receiver cannot stall;
// results are never held.
module ordered_stream_reorder_buffer_unit
    import ordrob_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [SLOT_W-1:0]    slot_id,
    input  logic [WORD_BITS-1:0] payload,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SLOT_W-1:0]    cfg_data,
    output logic                 result_valid,
    output logic [WORD_BITS-1:0] payload_out,
    output logic [SLOT_W-1:0]    slot_out,
    output logic                 last,
    output logic                 bad_slot
);

    mem_req_t             req;
    res_meta_t            meta;
    logic [WORD_BITS-1:0] rd_data;

    ordrob_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .slot_id   (slot_id),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .busy      (busy),
        .req       (req),
        .meta      (meta)
    );

    ordrob_store #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_store (
        .clk     (clk),
        .req     (req),
        .wr_data (payload),
        .rd_data (rd_data)
    );

    // Error items carry a zero word
    assign result_valid = meta.valid;
    assign payload_out  = meta.bad ? '0 : rd_data;
    assign slot_out     = meta.slot;
    assign last         = meta.last;
    assign bad_slot     = meta.bad;

endmodule

/* sim/ordered_stream_reorder_buffer_unit_tb.sv */
module ordered_stream_reorder_buffer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ordrob_pkg::*;

    localparam int ROB_DEPTH      = DEPTH_DEF;
    localparam int WORD_W         = WORD_BITS_DEF;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 270;
    localparam int MAX_REPORTS    = 10;

    // One released word or error item as seen on the result ports
    typedef struct {
        logic [WORD_W-1:0] word;
        logic [SLOT_W-1:0] slot;
        logic              last_flag;
        logic              bad_flag;
    } rob_result_t;

    // Scoreboard: tracks slot presence and head, queues the words each insert releases
    class rob_scoreboard;
        int unsigned       slot_count;
        int unsigned       head;
        bit                present [1:ROB_DEPTH];
        logic [WORD_W-1:0] words [1:ROB_DEPTH];
        rob_result_t       pending_releases [$];
        int unsigned       mismatches;
        int unsigned       results_checked;
        int unsigned       longest_run;
        int unsigned       bad_items;

        function new();
            slot_count      = ROB_DEPTH;
            mismatches      = 0;
            results_checked = 0;
            longest_run     = 0;
            bad_items       = 0;
            clear_stream();
        endfunction

        function void clear_stream();
            foreach (present[i])
                present[i] = 1'b0;
            head = 1;
        endfunction

        // Count write: 0 reads as 1, anything above the depth saturates
        function void set_count(logic [SLOT_W-1:0] value);
            if (value == 0)
                slot_count = 1;
            else if (value > ROB_DEPTH)
                slot_count = ROB_DEPTH;
            else
                slot_count = value;
            clear_stream();
        endfunction

        function int unsigned pending();
            return pending_releases.size();
        endfunction

        function void note_insert(logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] word);
            rob_result_t r;
            int unsigned run;
            // Out-of-range slot: a single error item, state untouched
            if (slot == 0 || slot > slot_count) begin
                r.word      = '0;
                r.slot      = '0;
                r.last_flag = 1'b0;
                r.bad_flag  = 1'b1;
                pending_releases.insert(pending_releases.size(), r);
                bad_items++;
                return;
            end
            words[slot]   = word;
            present[slot] = 1'b1;
            // Release the consecutive present run from the head
            run = 0;
            while (head <= slot_count && present[head]) begin
                r.word      = words[head];
                r.slot      = SLOT_W'(head);
                r.last_flag = !(head + 1 <= slot_count && present[head + 1]);
                r.bad_flag  = 1'b0;
                pending_releases.insert(pending_releases.size(), r);
                run++;
                head++;
            end
            if (run > longest_run)
                longest_run = run;
        endfunction

        function void report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR @%0t: %s", $time, msg);
        endfunction

        function void check_result(logic [WORD_W-1:0] word, logic [SLOT_W-1:0] slot,
                                   logic last_flag, logic bad_flag);
            rob_result_t exp;
            results_checked++;
            if (pending_releases.size() == 0) begin
                report_mismatch($sformatf("unexpected item: slot %0d payload %h last %b bad %b",
                                          slot, word, last_flag, bad_flag));
                return;
            end
            exp = pending_releases.pop_front();
            if (exp.word !== word || exp.slot !== slot || exp.last_flag !== last_flag ||
                exp.bad_flag !== bad_flag)
                report_mismatch($sformatf(
                    {"expected slot %0d payload %h last %b bad %b, ",
                     "got slot %0d payload %h last %b bad %b"},
                    exp.slot, exp.word, exp.last_flag, exp.bad_flag,
                    slot, word, last_flag, bad_flag));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [SLOT_W-1:0] slot_id;
    logic [WORD_W-1:0] payload;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SLOT_W-1:0] cfg_data;
    logic              result_valid;
    logic [WORD_W-1:0] payload_out;
    logic [SLOT_W-1:0] slot_out;
    logic              last;
    logic              bad_slot;

    rob_scoreboard sb;
    int unsigned   items_sent;
    int unsigned   count_writes;
    int unsigned   idle_cycles;

    ordered_stream_reorder_buffer_unit #(
        .DEPTH     (ROB_DEPTH),
        .WORD_BITS (WORD_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .slot_id      (slot_id),
        .payload      (payload),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .payload_out  (payload_out),
        .slot_out     (slot_out),
        .last         (last),
        .bad_slot     (bad_slot)
    );

    // 4 ns clock
    always #2 clk = ~clk;

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(payload_out, slot_out, last, bad_slot);
    end

    // Watchdog: cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("ordered_stream_reorder_buffer_unit verification failed");
            $finish;
        end
    end

    // Word with extremes mixed in
    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return WORD_W'($urandom);
    endfunction

    // Called at a falling edge; stop sending until every expected item is out
    task automatic wait_drained();
        start = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Called at a falling edge; returns at a falling edge with start still high
    task automatic send_item(logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] word, int unsigned gap);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   = 1'b1;
        slot_id = slot;
        payload = word;
        do
            @(posedge clk);
        while (busy);
        sb.note_insert(slot, word);
        items_sent++;
        @(negedge clk);
    endtask

    // Count write once the unit is idle
    task automatic write_count(logic [SLOT_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_count(value);
        count_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One random stream: pick a count, then fill its slots in some order with noise mixed in
    task automatic run_stream();
        int unsigned sel;
        int unsigned n;
        int unsigned order_kind;
        int unsigned j;
        int unsigned tmp;
        int unsigned noise;
        int unsigned extra;
        int unsigned slots [$];
        bit          burst;
        logic [SLOT_W-1:0] value;

        sel = $urandom_range(0, 9);
        if (sel == 0)
            value = SLOT_W'(ROB_DEPTH);
        else if (sel == 1)
            value = SLOT_W'(1);
        else if (sel == 2)
            value = '0;
        else if (sel == 3)
            value = SLOT_W'($urandom_range(ROB_DEPTH + 1, 63));
        else
            value = SLOT_W'($urandom_range(2, 8));
        write_count(value);
        n = sb.slot_count;

        for (int unsigned s = 1; s <= n; s++)
            slots.insert(slots.size(), s);
        order_kind = $urandom_range(0, 3);
        if (order_kind == 0) begin
            // reverse fill: unless noise fills a slot early, one insert releases the whole stream
            for (int unsigned i = 0; i < n / 2; i++) begin
                tmp              = slots[i];
                slots[i]         = slots[n - 1 - i];
                slots[n - 1 - i] = tmp;
            end
        end else if (order_kind > 1) begin
            for (int unsigned i = n - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = slots[i];
                slots[i] = slots[j];
                slots[j] = tmp;
            end
        end

        burst = ($urandom_range(0, 3) == 0);
        foreach (slots[i]) begin
            if ($urandom_range(0, 29) == 0)
                wait_drained();
            if ($urandom_range(0, 7) == 0) begin
                noise = $urandom_range(0, 2);
                if (noise == 0)
                    send_item('0, pick_word(), burst ? 0 : $urandom_range(0, 8));
                else if (noise == 1 && n < 63)
                    send_item(SLOT_W'($urandom_range(n + 1, 63)), pick_word(),
                              burst ? 0 : $urandom_range(0, 8));
                else
                    send_item(SLOT_W'($urandom_range(1, n)), pick_word(),
                              burst ? 0 : $urandom_range(0, 8));
            end
            send_item(SLOT_W'(slots[i]), pick_word(), burst ? 0 : $urandom_range(0, 8));
        end

        // inserts after the stream has finished release nothing
        if ($urandom_range(0, 2) == 0) begin
            extra = $urandom_range(1, 2);
            repeat (extra)
                send_item(SLOT_W'($urandom_range(1, n)), pick_word(), $urandom_range(0, 8));
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        slot_id      = '0;
        payload      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        items_sent   = 0;
        count_writes = 0;
        idle_cycles  = 0;
        sb           = new();

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: bad slots at the edges of the field
        send_item('0, 32'hDEAD_BEEF, 0);
        send_item(SLOT_W'(63), 32'hFFFF_FFFF, $urandom_range(0, 8));
        send_item(SLOT_W'(ROB_DEPTH + 1), 32'h1234_5678, $urandom_range(0, 8));
        // out-of-order inserts, refill before release, then one insert frees three
        send_item(SLOT_W'(3), 32'hFFFF_FFFF, $urandom_range(0, 8));
        send_item(SLOT_W'(2), 32'h0000_0000, 0);
        send_item(SLOT_W'(2), 32'h1234_5678, $urandom_range(0, 8));
        send_item(SLOT_W'(1), 32'hA5A5_A5A5, 0);
        // refill behind the head: stored, never released
        send_item(SLOT_W'(1), 32'h5A5A_5A5A, $urandom_range(0, 8));
        send_item(SLOT_W'(4), 32'h0F0F_0F0F, $urandom_range(0, 8));
        // hold off mid-stream until everything is out
        wait_drained();
        send_item(SLOT_W'(6), 32'hF0F0_F0F0, $urandom_range(0, 8));
        send_item(SLOT_W'(5), 32'h8000_0001, 0);

        // count 0 reads as 1; the stream finishes after one word
        write_count('0);
        send_item(SLOT_W'(1), 32'h7FFF_FFFF, 0);
        send_item(SLOT_W'(1), 32'hC3C3_C3C3, $urandom_range(0, 8));
        send_item(SLOT_W'(2), 32'h3C3C_3C3C, $urandom_range(0, 8));

        // count above the depth saturates
        write_count(SLOT_W'(63));
        send_item(SLOT_W'(ROB_DEPTH), 32'hFFFF_FFFF, 0);
        send_item(SLOT_W'(ROB_DEPTH - 1), 32'h0000_0000, 0);

        write_count(SLOT_W'(2));
        send_item(SLOT_W'(2), 32'h1111_2222, 0);
        send_item(SLOT_W'(1), 32'h3333_4444, $urandom_range(0, 8));
        send_item(SLOT_W'(3), 32'h5555_6666, 0);

        // Random streams
        while (items_sent < TARGET_ITEMS)
            run_stream();

        wait_drained();
        repeat (SETTLE_CYCLES * 2) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected items never arrived", sb.pending()));

        $display("Sent %0d items across %0d count settings; checked %0d result items",
                 items_sent, count_writes, sb.results_checked);
        $display("Bad-slot items: %0d, longest release run: %0d, mismatches: %0d",
                 sb.bad_items, sb.longest_run, sb.mismatches);
        if (sb.mismatches == 0)
            $display("ordered_stream_reorder_buffer_unit verification clean");
        else
            $display("ordered_stream_reorder_buffer_unit verification failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/ordrob_pkg.sv
hw/rtl/ordrob_store.sv
hw/rtl/ordrob_ctrl.sv
hw/rtl/ordered_stream_reorder_buffer_unit.sv
sim/ordered_stream_reorder_buffer_unit_tb.sv
